// ===== sv/twg_pkg.sv =====
package twg_pkg;

  // Register map of the configuration channel
  typedef enum logic [1:0] {
    REG_SHAPE     = 2'd0,
    REG_AMPLITUDE = 2'd1,
    REG_FREQUENCY = 2'd2,
    REG_ENABLE    = 2'd3
  } cfg_reg_t;

  // Waveform shapes; the last code plays the sine table too
  typedef enum logic [1:0] {
    SHAPE_SINE     = 2'd0,
    SHAPE_TRIANGLE = 2'd1,
    SHAPE_SQUARE   = 2'd2,
    SHAPE_SINE_ALT = 2'd3
  } shape_t;

  localparam int SHAPE_W = 2;
  localparam int AMP_W   = 7;
  localparam int FREQ_W  = 12;
  localparam int CFG_W   = 12;
  localparam int LEVEL_W = 8;
  localparam int INTV_W  = 16;
  localparam int PROD_W  = LEVEL_W + AMP_W;

  localparam logic [AMP_W-1:0]   AMP_MAX      = 7'd100;
  localparam logic [AMP_W-1:0]   AMP_RESET    = 7'd100;
  localparam logic [FREQ_W-1:0]  FREQ_MIN     = 12'd1;
  localparam logic [FREQ_W-1:0]  FREQ_MAX     = 12'd3000;
  localparam int                 FREQ_RESET   = 1000;
  localparam int                 FREQ_MAX_INT = 3000;
  localparam logic [INTV_W-1:0]  INTV_MAX     = 16'd65535;
  localparam logic [LEVEL_W-1:0] LEVEL_FULL   = 8'd255;

  // x / 100 as (x * 20972) >> 21, exact for x up to 255 * 100
  localparam logic [PROD_W-1:0] DIV100_MUL   = 15'd20972;
  localparam int                DIV100_SHIFT = 21;

  // 64-point sine base table (Taylor polynomial, truncated and clamped)
  localparam int SINE_POINTS = 64;
  localparam logic [LEVEL_W-1:0] SINE_ROM [SINE_POINTS] = '{
    8'd128, 8'd140, 8'd152, 8'd164, 8'd176, 8'd187, 8'd198, 8'd208,
    8'd217, 8'd226, 8'd233, 8'd240, 8'd245, 8'd249, 8'd252, 8'd254,
    8'd255, 8'd255, 8'd253, 8'd251, 8'd248, 8'd243, 8'd238, 8'd233,
    8'd227, 8'd221, 8'd214, 8'd208, 8'd203, 8'd199, 8'd195, 8'd194,
    8'd194, 8'd61,  8'd60,  8'd56,  8'd52,  8'd47,  8'd41,  8'd34,
    8'd28,  8'd22,  8'd17,  8'd12,  8'd7,   8'd4,   8'd2,   8'd0,
    8'd0,   8'd1,   8'd3,   8'd6,   8'd10,  8'd15,  8'd22,  8'd29,
    8'd38,  8'd47,  8'd57,  8'd68,  8'd79,  8'd91,  8'd103, 8'd115
  };

endpackage

// ===== sv/twg_ram.sv =====
module twg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/table_waveform_generator.sv =====
// channel | direction | handshake          | payload
// in_     | slave     | in_tvalid/tready   | in_tdata[0] clock_tick
// out_    | master    | out_tvalid/tready  | out_tdata[7:0] dac_level, out_tuser level_updated
// cfg_    | slave     | cfg_valid/ready    | cfg_index register, cfg_data[11:0] value
//
// One tick item per cycle while in_tready is high; each result passes the stages
// index/RAM read, base * amplitude and divide by 100 into the held level, in order.
// rst_n is synchronous; after reset and after every shape write the base table RAM
// is reloaded, one entry a cycle, with in_tready low until the load is done.
// After a frequency write the interval divider runs one quotient bit a cycle,
// with in_tready low until the new interval is in place.
// out_tready low under out_tvalid stalls every stage; in_tready follows it in the same cycle.
module table_waveform_generator
  import twg_pkg::*;
#(
  parameter int TABLE_DEPTH   = 64,
  parameter int WAVE_CLOCK_HZ = 1000000
) (
  input  logic              clk,
  input  logic              rst_n,
  // input ticks
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [0] clock_tick, [7:1] zero
  // results
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,  // [7:0] dac_level
  output logic              out_tuser,  // [0] level_updated
  // configuration writes
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int CW     = $clog2(TABLE_DEPTH + 1);
  localparam int HALF   = TABLE_DEPTH / 2;
  localparam int HM1    = HALF - 1;
  // sine ROM position i*64/DEPTH kept as quotient and remainder
  localparam int SIN_Q  = SINE_POINTS / TABLE_DEPTH;
  localparam int SIN_R  = SINE_POINTS % TABLE_DEPTH;
  // triangle ramp 255*i/(HALF-1) kept the same way
  localparam int TRI_Q  = 255 / HM1;
  localparam int TRI_R  = 255 % HM1;
  // interval divider
  localparam int NW     = $clog2(WAVE_CLOCK_HZ + 1);
  localparam int DW     = $clog2(FREQ_MAX_INT * TABLE_DEPTH + 1);
  localparam int DCW    = $clog2(NW);
  localparam int RST_RAW  = WAVE_CLOCK_HZ / (FREQ_RESET * TABLE_DEPTH);
  localparam int RST_INTV = (RST_RAW < 1) ? 1 : ((RST_RAW > 65535) ? 65535 : RST_RAW);

  localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [IDX_W:0]   HALF_X     = (IDX_W+1)'(HALF);
  localparam logic [IDX_W:0]   TWO_HALF_X = (IDX_W+1)'(2 * HALF);
  localparam logic [CW:0]      DEPTH_X    = (CW+1)'(TABLE_DEPTH);
  localparam logic [CW:0]      HM1_X      = (CW+1)'(HM1);
  localparam logic [NW-1:0]    DIVIDEND   = NW'(WAVE_CLOCK_HZ);
  localparam logic [DW-1:0]    DEPTH_D    = DW'(TABLE_DEPTH);

  // ---------------- configuration registers ----------------
  logic [SHAPE_W-1:0] wave_shape_r;
  logic [AMP_W-1:0]   amplitude_r;
  logic               output_enable_r;
  logic [FREQ_W-1:0]  freq_clamped;
  logic [AMP_W-1:0]   amp_clamped;
  logic               cfg_xfer;

  // ---------------- timer and index ----------------
  logic [INTV_W-1:0]  tick_counter_r;
  logic [INTV_W-1:0]  tick_interval_r;
  logic [INTV_W-1:0]  counter_inc;
  logic [IDX_W-1:0]   table_index_r;
  logic               in_xfer;
  logic               fire;

  // ---------------- table load sweep ----------------
  logic               sweep_busy_r;
  logic [IDX_W-1:0]   sweep_idx_r;
  logic [5:0]         sine_q_r;
  logic [CW-1:0]      sine_rem_r;
  logic [7:0]         tri_q_r;
  logic [CW-1:0]      tri_rem_r;
  logic [CW:0]        sine_sum;
  logic [CW:0]        tri_sum;
  logic [IDX_W:0]     sweep_idx_x;
  logic [LEVEL_W-1:0] sweep_wdata;

  // ---------------- interval divider ----------------
  logic               div_busy_r;
  logic [DCW-1:0]     div_cnt_r;
  logic [DW-1:0]      div_den_r;
  logic [DW-1:0]      div_rem_r;
  logic [NW-1:0]      div_quo_r;
  logic [DW:0]        div_shift;
  logic               div_ge;
  logic [DW-1:0]      div_rem_nxt;
  logic [NW-1:0]      div_quo_nxt;
  logic [INTV_W-1:0]  div_result;

  // ---------------- pipeline ----------------
  logic                   advance;
  logic                   s1_valid_r;
  logic                   s1_fire_r;
  logic                   s2_valid_r;
  logic                   s2_fire_r;
  logic [PROD_W-1:0]      s2_prod_r;
  logic                   out_valid_r;
  logic                   out_fire_r;
  logic [LEVEL_W-1:0]     held_level_r;
  logic [LEVEL_W-1:0]     ram_rdata;
  logic [2*PROD_W-1:0]    div100_prod;
  logic [LEVEL_W-1:0]     level_calc;

  // handshakes
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = advance && !sweep_busy_r && !div_busy_r;
  assign in_xfer   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid && cfg_ready;

  // write value saturation
  always_comb begin
    amp_clamped = (cfg_data[AMP_W-1:0] > AMP_MAX) ? AMP_MAX : cfg_data[AMP_W-1:0];
    if (cfg_data[FREQ_W-1:0] < FREQ_MIN) begin
      freq_clamped = FREQ_MIN;
    end else if (cfg_data[FREQ_W-1:0] > FREQ_MAX) begin
      freq_clamped = FREQ_MAX;
    end else begin
      freq_clamped = cfg_data[FREQ_W-1:0];
    end
  end

  // sample timer
  assign counter_inc = tick_counter_r + INTV_W'(1);
  assign fire        = in_xfer && in_tdata[0] && (counter_inc >= tick_interval_r);

  // divider step: one quotient bit per cycle
  always_comb begin
    div_shift   = {div_rem_r, DIVIDEND[div_cnt_r]};
    div_ge      = div_shift >= {1'b0, div_den_r};
    div_rem_nxt = div_ge ? DW'(div_shift - {1'b0, div_den_r}) : div_shift[DW-1:0];
    div_quo_nxt = {div_quo_r[NW-2:0], div_ge};
    if (div_quo_nxt > NW'(INTV_MAX)) begin
      div_result = INTV_MAX;
    end else if (div_quo_nxt == '0) begin
      div_result = INTV_W'(1);
    end else begin
      div_result = div_quo_nxt[INTV_W-1:0];
    end
  end

  // config, timer, index and divider state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_shape_r    <= SHAPE_SINE;
      amplitude_r     <= AMP_RESET;
      output_enable_r <= 1'b0;
      tick_counter_r  <= '0;
      tick_interval_r <= INTV_W'(RST_INTV);
      table_index_r   <= '0;
      div_busy_r      <= 1'b0;
      div_cnt_r       <= '0;
    end else begin
      // ticks
      if (in_xfer && in_tdata[0]) begin
        tick_counter_r <= fire ? '0 : counter_inc;
      end
      if (fire && output_enable_r) begin
        table_index_r <= (table_index_r == IDX_LAST) ? '0 : table_index_r + IDX_W'(1);
      end
      // divider iterations
      if (div_busy_r) begin
        if (div_cnt_r == '0) begin
          div_busy_r      <= 1'b0;
          tick_interval_r <= div_result;
        end else begin
          div_cnt_r <= div_cnt_r - DCW'(1);
        end
      end
      // register writes
      if (cfg_xfer) begin
        case (cfg_reg_t'(cfg_index))
          REG_SHAPE: begin
            wave_shape_r <= cfg_data[SHAPE_W-1:0];
          end
          REG_AMPLITUDE: begin
            amplitude_r <= amp_clamped;
          end
          REG_FREQUENCY: begin
            tick_counter_r <= '0;
            div_busy_r     <= 1'b1;
            div_cnt_r      <= DCW'(NW - 1);
          end
          REG_ENABLE: begin
            output_enable_r <= cfg_data[0];
            if (!cfg_data[0]) begin
              table_index_r <= '0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // divider datapath
  always_ff @(posedge clk) begin
    if (cfg_xfer && cfg_reg_t'(cfg_index) == REG_FREQUENCY) begin
      div_den_r <= DW'(freq_clamped) * DEPTH_D;
      div_rem_r <= '0;
      div_quo_r <= '0;
    end else if (div_busy_r) begin
      div_rem_r <= div_rem_nxt;
      div_quo_r <= div_quo_nxt;
    end
  end

  // base table entry for the sweep position
  assign sweep_idx_x = {1'b0, sweep_idx_r};
  always_comb begin
    case (shape_t'(wave_shape_r))
      SHAPE_TRIANGLE: begin
        if (sweep_idx_x < HALF_X) begin
          sweep_wdata = tri_q_r;
        end else if (sweep_idx_x < TWO_HALF_X) begin
          sweep_wdata = LEVEL_FULL - tri_q_r;
        end else begin
          sweep_wdata = '0;
        end
      end
      SHAPE_SQUARE: begin
        sweep_wdata = (sweep_idx_x < HALF_X) ? '0 : LEVEL_FULL;
      end
      default: begin
        sweep_wdata = SINE_ROM[sine_q_r];
      end
    endcase
  end

  assign sine_sum = {1'b0, sine_rem_r} + (CW+1)'(SIN_R);
  assign tri_sum  = {1'b0, tri_rem_r} + (CW+1)'(TRI_R);

  // table load sweep; a shape write starts it over
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_busy_r <= 1'b1;
      sweep_idx_r  <= '0;
      sine_q_r     <= '0;
      sine_rem_r   <= '0;
      tri_q_r      <= '0;
      tri_rem_r    <= '0;
    end else if (cfg_xfer && cfg_reg_t'(cfg_index) == REG_SHAPE) begin
      sweep_busy_r <= 1'b1;
      sweep_idx_r  <= '0;
      sine_q_r     <= '0;
      sine_rem_r   <= '0;
      tri_q_r      <= '0;
      tri_rem_r    <= '0;
    end else if (sweep_busy_r) begin
      sweep_idx_r <= sweep_idx_r + IDX_W'(1);
      if (sweep_idx_r == IDX_LAST) begin
        sweep_busy_r <= 1'b0;
      end
      // next sine position
      if (sine_sum >= DEPTH_X) begin
        sine_rem_r <= CW'(sine_sum - DEPTH_X);
        sine_q_r   <= sine_q_r + 6'(SIN_Q) + 6'd1;
      end else begin
        sine_rem_r <= sine_sum[CW-1:0];
        sine_q_r   <= sine_q_r + 6'(SIN_Q);
      end
      // next triangle ramp value; the down ramp restarts at half depth
      if (sweep_idx_x + (IDX_W+1)'(1) == HALF_X) begin
        tri_rem_r <= '0;
        tri_q_r   <= '0;
      end else if (tri_sum >= HM1_X) begin
        tri_rem_r <= CW'(tri_sum - HM1_X);
        tri_q_r   <= tri_q_r + 8'(TRI_Q) + 8'd1;
      end else begin
        tri_rem_r <= tri_sum[CW-1:0];
        tri_q_r   <= tri_q_r + 8'(TRI_Q);
      end
    end
  end

  // base table memory: sweep writes, reads at the current index whenever the pipeline advances
  twg_ram #(
    .WIDTH (LEVEL_W),
    .DEPTH (TABLE_DEPTH)
  ) u_base_ram (
    .clk   (clk),
    .we    (sweep_busy_r),
    .waddr (sweep_idx_r),
    .wdata (sweep_wdata),
    .re    (advance),
    .raddr (table_index_r),
    .rdata (ram_rdata)
  );

  // scale by percent: x / 100 by reciprocal multiply
  assign div100_prod = {{PROD_W{1'b0}}, s2_prod_r} * {{PROD_W{1'b0}}, DIV100_MUL};
  assign level_calc  = div100_prod[DIV100_SHIFT +: LEVEL_W];

  // pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      s2_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      held_level_r <= '0;
    end else begin
      if (advance) begin
        s1_valid_r  <= in_xfer;
        s2_valid_r  <= s1_valid_r;
        out_valid_r <= s2_valid_r;
        if (s2_valid_r && s2_fire_r) begin
          held_level_r <= output_enable_r ? level_calc : '0;
        end
      end
      if (cfg_xfer && cfg_reg_t'(cfg_index) == REG_ENABLE && !cfg_data[0]) begin
        held_level_r <= '0;
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_fire_r  <= fire;
      s2_fire_r  <= s1_fire_r;
      s2_prod_r  <= PROD_W'(ram_rdata) * PROD_W'(amplitude_r);
      out_fire_r <= s2_fire_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = held_level_r;
  assign out_tuser  = out_fire_r;

  // ---------------- assertions ----------------
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !sweep_busy_r && !div_busy_r)
    else $error("tick accepted during table load or interval divide");

  a_counter_range: assert property (@(posedge clk) disable iff (!rst_n)
    tick_counter_r < tick_interval_r)
    else $error("tick counter reached interval");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    table_index_r <= IDX_LAST)
    else $error("table index beyond depth");

  a_disabled_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_fire_r && !output_enable_r |-> held_level_r == '0)
    else $error("disabled firing left a nonzero level");

  a_pipe_flow: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && advance |=> out_valid_r)
    else $error("result lost between scale stage and output");

endmodule
